// ===== rtl/core/typed_buffer_occupancy_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// typed buffer occupancy tracker assertion macros
// concurrent checks sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TYPED_BUFFER_OCCUPANCY_TRACKER_UNIT_ASSERT_SVH
`define TYPED_BUFFER_OCCUPANCY_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// plain property check
`define TBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication check
`define TBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TBO_ASSERT(lbl, prop, msg)
`define TBO_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// shared types, codes and defaults of the typed buffer occupancy tracker
// ----------------------------------------------------------------------------
package tbo_pkg;

  // default level width of one per-type counter
  localparam int unsigned LEVEL_WIDTH_DEF = 16;

  // fixed field widths
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned TOTAL_W = 18;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned NTYPES  = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_EVICT  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READY  = 2'd3
  } command_e;

  // data type codes
  localparam logic [1:0] TYPE_INPUT   = 2'd0;
  localparam logic [1:0] TYPE_WEIGHT  = 2'd1;
  localparam logic [1:0] TYPE_OUTPUT  = 2'd2;
  localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_CAPACITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_CAPACITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CAPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 3'd4;

  // buffer mode values
  localparam logic MODE_SHARED      = 1'b0;
  localparam logic MODE_INDEPENDENT = 1'b1;

  // one command item
  typedef struct packed {
    command_e        command;
    logic [1:0]      data_type;
    logic [2:0]      type_mask;
    logic [AMT_W-1:0] amount;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic               accepted;
    logic [AMT_W-1:0]   amount_moved;
    logic [AMT_W-1:0]   type_level;
    logic [TOTAL_W-1:0] total_level;
    logic               type_full;
    logic               ready_res;
  } res_t;

  // configuration register set
  typedef struct packed {
    logic                         buffer_mode;
    logic [CAP_W-1:0]             shared_capacity;
    logic [NTYPES-1:0][CAP_W-1:0] type_capacity;
  } cfg_t;

endpackage

// ===== rtl/core/tbo_stream_if.sv =====
// ----------------------------------------------------------------------------
// tbo command and result channels
// valid/ready channels carrying one command item or one result item
// ----------------------------------------------------------------------------
interface tbo_cmd_if;
  logic                      valid;
  logic                      ready;
  tbo_pkg::command_e         command;
  logic [1:0]                data_type;
  logic [2:0]                type_mask;
  logic [tbo_pkg::AMT_W-1:0] amount;

  modport source (output valid, command, data_type, type_mask, amount, input ready);
  modport sink   (input valid, command, data_type, type_mask, amount, output ready);
endinterface

interface tbo_res_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [tbo_pkg::AMT_W-1:0]   amount_moved;
  logic [tbo_pkg::AMT_W-1:0]   type_level;
  logic [tbo_pkg::TOTAL_W-1:0] total_level;
  logic                        type_full;
  logic                        ready_res;

  modport source (output valid, accepted, amount_moved, type_level, total_level,
                  type_full, ready_res, input ready);
  modport sink   (input valid, accepted, amount_moved, type_level, total_level,
                  type_full, ready_res, output ready);
endinterface

// ===== rtl/core/typed_buffer_occupancy_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// typed_buffer_occupancy_tracker_unit
// tracks input, weight and output levels of an accelerator buffer
// ----------------------------------------------------------------------------
// flow: an accepted item is held in the item register, and its result is
//   registered in the result register once that register is free
// throughput: one item per cycle unless the result side stalls; the level
//   update and result are combinational between the item and result registers
// reset: levels, capacities, buffer mode and both valid flags clear at once
// ----------------------------------------------------------------------------
module typed_buffer_occupancy_tracker_unit #(
  parameter int unsigned LEVEL_WIDTH = tbo_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tbo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbo_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  tbo_cmd_if.sink                       cmd_i,
  tbo_res_if.source                     res_o
);

  tbo_pkg::cfg_t cfg;
  tbo_pkg::cmd_t item_q, item_d;
  tbo_pkg::res_t res_q, res_d;
  logic          item_valid_q, item_valid_d;
  logic          res_valid_q, res_valid_d;
  logic          res_free, step, cmd_take;

  // configuration registers
  tbo_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  // handshake between item register and result register
  assign res_free     = !res_valid_q || res_o.ready;
  assign step         = item_valid_q && res_free;
  assign cmd_i.ready  = !item_valid_q || res_free;
  assign cmd_take     = cmd_i.valid && cmd_i.ready;
  assign item_valid_d = cmd_take || (item_valid_q && !step);
  assign res_valid_d  = step || (res_valid_q && !res_o.ready);

  always_comb begin
    item_d.command   = cmd_i.command;
    item_d.data_type = cmd_i.data_type;
    item_d.type_mask = cmd_i.type_mask;
    item_d.amount    = cmd_i.amount;
  end

  // level counters and command evaluation
  tbo_level_core #(
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .step_i (step),
    .cmd_i  (item_q),
    .res_o  (res_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  // result channel
  assign res_o.valid        = res_valid_q;
  assign res_o.accepted     = res_q.accepted;
  assign res_o.amount_moved = res_q.amount_moved;
  assign res_o.type_level   = res_q.type_level;
  assign res_o.total_level  = res_q.total_level;
  assign res_o.type_full    = res_q.type_full;
  assign res_o.ready_res    = res_q.ready_res;

endmodule

// ===== rtl/core/tbo_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbo_cfg_regs
// buffer mode and capacity registers behind the plain write port
// ----------------------------------------------------------------------------
module tbo_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tbo_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tbo_pkg::CFG_DAT_W-1:0]       cfg_wdata_i,
  output tbo_pkg::cfg_t                       cfg_o
);

  tbo_pkg::cfg_t cfg_q, cfg_d;

  // decode register writes, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbo_pkg::REG_BUFFER_MODE:     cfg_d.buffer_mode      = cfg_wdata_i[0];
        tbo_pkg::REG_SHARED_CAPACITY: cfg_d.shared_capacity  = cfg_wdata_i;
        tbo_pkg::REG_INPUT_CAPACITY:  cfg_d.type_capacity[0] = cfg_wdata_i;
        tbo_pkg::REG_WEIGHT_CAPACITY: cfg_d.type_capacity[1] = cfg_wdata_i;
        tbo_pkg::REG_OUTPUT_CAPACITY: cfg_d.type_capacity[2] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/tbo_level_core.sv =====
// ----------------------------------------------------------------------------
// tbo_level_core
// per-type and total level counters with the combinational command evaluation
// ----------------------------------------------------------------------------
`include "typed_buffer_occupancy_tracker_unit_assert.svh"

module tbo_level_core #(
  parameter int unsigned LEVEL_WIDTH = tbo_pkg::LEVEL_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tbo_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  tbo_pkg::cmd_t cmd_i,
  output tbo_pkg::res_t res_o
);

  // working width covers the total level and any level plus amount
  localparam int unsigned OW = LEVEL_WIDTH + 2;
  localparam int unsigned SW = ((LEVEL_WIDTH > tbo_pkg::AMT_W) ?
                                LEVEL_WIDTH : tbo_pkg::AMT_W) + 2;
  localparam logic [SW-1:0] LEVEL_MAX = SW'({LEVEL_WIDTH{1'b1}});

  logic [LEVEL_WIDTH-1:0] lvl_q [tbo_pkg::NTYPES];
  logic [LEVEL_WIDTH-1:0] lvl_d [tbo_pkg::NTYPES];
  logic [OW-1:0]          total_q, total_d;

  logic                   known;
  logic [SW-1:0]          amt, lvl_t, cap_t, total, shared_cap;
  logic [SW-1:0]          sum_t, sum_total;
  logic                   fits;
  logic                   accepted, ready, write_en, adding;
  logic [SW-1:0]          moved;
  logic [SW-1:0]          new_lvl_t, new_total;
  logic                   full;

  // select the addressed type
  always_comb begin
    known = 1'b1;
    lvl_t = '0;
    cap_t = '0;
    case (cmd_i.data_type)
      tbo_pkg::TYPE_INPUT: begin
        lvl_t = SW'(lvl_q[0]);
        cap_t = SW'(cfg_i.type_capacity[0]);
      end
      tbo_pkg::TYPE_WEIGHT: begin
        lvl_t = SW'(lvl_q[1]);
        cap_t = SW'(cfg_i.type_capacity[1]);
      end
      tbo_pkg::TYPE_OUTPUT: begin
        lvl_t = SW'(lvl_q[2]);
        cap_t = SW'(cfg_i.type_capacity[2]);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign amt        = SW'(cmd_i.amount);
  assign total      = SW'(total_q);
  assign shared_cap = SW'(cfg_i.shared_capacity);
  assign sum_t      = lvl_t + amt;
  assign sum_total  = total + amt;

  // capacity check of an add, with counter overflow treated as no fit
  always_comb begin
    if (cfg_i.buffer_mode == tbo_pkg::MODE_INDEPENDENT) begin
      fits = (sum_t <= cap_t);
    end else begin
      fits = (sum_total <= shared_cap);
    end
    if (sum_t > LEVEL_MAX) begin
      fits = 1'b0;
    end
  end

  // readiness over the masked types
  always_comb begin
    ready = 1'b1;
    for (int i = 0; i < tbo_pkg::NTYPES; i++) begin
      if (cmd_i.type_mask[i] && (SW'(lvl_q[i]) < amt)) begin
        ready = 1'b0;
      end
    end
  end

  // command evaluation
  always_comb begin
    accepted = 1'b0;
    moved    = '0;
    adding   = 1'b0;
    case (cmd_i.command)
      tbo_pkg::CMD_ADD: begin
        adding = 1'b1;
        if (known && fits) begin
          accepted = 1'b1;
          moved    = amt;
        end
      end
      tbo_pkg::CMD_EVICT: begin
        accepted = 1'b1;
        moved    = (amt < lvl_t) ? amt : lvl_t;
      end
      tbo_pkg::CMD_REMOVE: begin
        if (known && (total >= amt) && (lvl_t >= amt)) begin
          accepted = 1'b1;
          moved    = amt;
        end
      end
      default: ;
    endcase
  end

  // new levels after this item
  assign new_lvl_t = adding ? (lvl_t + moved) : (lvl_t - moved);
  assign new_total = adding ? (total + moved) : (total - moved);
  assign write_en  = step_i && known && (cmd_i.command != tbo_pkg::CMD_READY)
                     && accepted;

  always_comb begin
    for (int i = 0; i < tbo_pkg::NTYPES; i++) begin
      lvl_d[i] = lvl_q[i];
      if (write_en && (cmd_i.data_type == 2'(i))) begin
        lvl_d[i] = LEVEL_WIDTH'(new_lvl_t);
      end
    end
    total_d = write_en ? OW'(new_total) : total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tbo_pkg::NTYPES; i++) begin
        lvl_q[i] <= '0;
      end
      total_q <= '0;
    end else begin
      lvl_q   <= lvl_d;
      total_q <= total_d;
    end
  end

  // full flag seen after this item
  always_comb begin
    if (!known) begin
      full = 1'b0;
    end else if (cfg_i.buffer_mode == tbo_pkg::MODE_INDEPENDENT) begin
      full = (new_lvl_t >= cap_t);
    end else begin
      full = (new_total >= shared_cap);
    end
  end

  // result item
  always_comb begin
    res_o.accepted     = accepted;
    res_o.amount_moved = tbo_pkg::AMT_W'(moved);
    res_o.type_level   = known ? tbo_pkg::AMT_W'(new_lvl_t) : '0;
    res_o.total_level  = tbo_pkg::TOTAL_W'(new_total);
    res_o.type_full    = full;
    res_o.ready_res    = (cmd_i.command == tbo_pkg::CMD_READY) ? ready : 1'b0;
  end

  // checks
  `TBO_ASSERT(a_total_is_sum,
    total_q == (OW'(lvl_q[0]) + OW'(lvl_q[1]) + OW'(lvl_q[2])),
    "total level differs from the sum of type levels")
  `TBO_ASSERT_NEXT(a_ready_keeps_levels,
    step_i && (cmd_i.command == tbo_pkg::CMD_READY),
    $stable(total_q) && $stable(lvl_q[0]) && $stable(lvl_q[1]) && $stable(lvl_q[2]),
    "readiness check changed a level")
  `TBO_ASSERT_NEXT(a_reject_keeps_total,
    step_i && !accepted,
    $stable(total_q),
    "rejected item changed the total level")
  `TBO_ASSERT_NEXT(a_drain_never_grows,
    step_i && (cmd_i.command != tbo_pkg::CMD_ADD),
    total_q <= $past(total_q),
    "evict or remove raised the total level")

endmodule

// ===== verif/tbo_occupancy_checker.sv =====
// ----------------------------------------------------------------------------
// tbo occupancy checker
// snoops the register write port and both item channels, keeps its own copy
// of the buffer levels and capacities, predicts each result item and compares
// it field by field with what the tracker returns
// ----------------------------------------------------------------------------
module tbo_occupancy_checker
  import tbo_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = tbo_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  tbo_cmd_if                   cmd_mon_i,
  tbo_res_if                   res_mon_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [19:0] LEVEL_MAX = 20'((64'd1 << LEVEL_WIDTH) - 64'd1);
  localparam int unsigned REPORT_LIMIT = 10;

  // shadow of the tracker registers and levels
  logic               shadow_mode;
  logic [CAP_W-1:0]   shadow_shared_cap;
  logic [CAP_W-1:0]   shadow_type_cap[NTYPES];
  logic [AMT_W-1:0]   type_level[NTYPES];
  logic [TOTAL_W-1:0] total_level;

  // results still owed by the tracker, oldest first
  res_t owed_results_q[$];

  // full flag of one known type under the current mode
  function automatic logic full_of(int unsigned t);
    if (shadow_mode == MODE_SHARED) begin
      return 20'(total_level) >= 20'(shadow_shared_cap);
    end
    return type_level[t] >= shadow_type_cap[t];
  endfunction

  // apply one command item to the shadow levels and build its result item
  function automatic res_t apply_occupancy_command(cmd_t c);
    res_t        r;
    logic        known;
    logic        fits;
    int unsigned t;
    logic [19:0] type_sum;
    logic [19:0] total_sum;
    logic [AMT_W-1:0] moved;

    r     = '0;
    known = (c.data_type != TYPE_UNKNOWN);
    t     = c.data_type;

    case (c.command)
      CMD_ADD: begin
        if (known) begin
          type_sum  = 20'(type_level[t]) + 20'(c.amount);
          total_sum = 20'(total_level) + 20'(c.amount);
          if (shadow_mode == MODE_SHARED) begin
            fits = total_sum <= 20'(shadow_shared_cap);
          end else begin
            fits = type_sum <= 20'(shadow_type_cap[t]);
          end
          // a type counter never wraps
          if (type_sum > LEVEL_MAX) begin
            fits = 1'b0;
          end
          if (fits) begin
            type_level[t]  = type_level[t] + c.amount;
            total_level    = total_level + TOTAL_W'(c.amount);
            r.accepted     = 1'b1;
            r.amount_moved = c.amount;
          end
        end
      end
      CMD_EVICT: begin
        r.accepted = 1'b1;
        if (known) begin
          moved          = (c.amount < type_level[t]) ? c.amount : type_level[t];
          type_level[t]  = type_level[t] - moved;
          total_level    = total_level - TOTAL_W'(moved);
          r.amount_moved = moved;
        end
      end
      CMD_REMOVE: begin
        if (known && total_level >= TOTAL_W'(c.amount) && type_level[t] >= c.amount) begin
          type_level[t]  = type_level[t] - c.amount;
          total_level    = total_level - TOTAL_W'(c.amount);
          r.accepted     = 1'b1;
          r.amount_moved = c.amount;
        end
      end
      default: begin
        // readiness check, an empty mask is ready
        r.ready_res = 1'b1;
        for (int i = 0; i < NTYPES; i++) begin
          if (c.type_mask[i] && type_level[i] < c.amount) begin
            r.ready_res = 1'b0;
          end
        end
      end
    endcase

    r.total_level = total_level;
    if (known) begin
      r.type_level = type_level[t];
      r.type_full  = full_of(t);
    end
    return r;
  endfunction

  // count a mismatch, print only the first few
  task automatic flag_mismatch(string what);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic check_field(string name, int unsigned want, logic [31:0] got);
    if (got !== 32'(want)) begin
      flag_mismatch($sformatf("result %0d field %s expected %0d actual %0d",
                              checked_o, name, want, got));
    end
  endtask

  // snoop writes, results and command items on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t got_cmd;
    res_t want;
    if (!rst_ni) begin
      shadow_mode       = MODE_SHARED;
      shadow_shared_cap = '0;
      total_level       = '0;
      for (int i = 0; i < NTYPES; i++) begin
        shadow_type_cap[i] = '0;
        type_level[i]      = '0;
      end
      owed_results_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BUFFER_MODE:     shadow_mode        = cfg_wdata_i[0];
          REG_SHARED_CAPACITY: shadow_shared_cap  = cfg_wdata_i;
          REG_INPUT_CAPACITY:  shadow_type_cap[0] = cfg_wdata_i;
          REG_WEIGHT_CAPACITY: shadow_type_cap[1] = cfg_wdata_i;
          REG_OUTPUT_CAPACITY: shadow_type_cap[2] = cfg_wdata_i;
          default: ;
        endcase
      end

      // result items are matched before this edge's command item is queued
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (owed_results_q.size() == 0) begin
          flag_mismatch($sformatf("result item with nothing expected, total %0d",
                                  res_mon_i.total_level));
        end else begin
          want = owed_results_q.pop_front();
          check_field("accepted",     want.accepted,     res_mon_i.accepted);
          check_field("amount_moved", want.amount_moved, res_mon_i.amount_moved);
          check_field("type_level",   want.type_level,   res_mon_i.type_level);
          check_field("total_level",  want.total_level,  res_mon_i.total_level);
          check_field("type_full",    want.type_full,    res_mon_i.type_full);
          check_field("ready_res",    want.ready_res,    res_mon_i.ready_res);
        end
        checked_o++;
      end

      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        got_cmd.command   = cmd_mon_i.command;
        got_cmd.data_type = cmd_mon_i.data_type;
        got_cmd.type_mask = cmd_mon_i.type_mask;
        got_cmd.amount    = cmd_mon_i.amount;
        owed_results_q.push_back(apply_occupancy_command(got_cmd));
      end

      pending_o = owed_results_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the occupancy tracker with directed corner items and then random
// phases of add, evict, remove and readiness items under changing buffer
// modes and capacities; both channels idle at random, the result side holds
// off once for a long stretch, and the checker judges every result item
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tbo_pkg::*;

  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned MAX_GAP        = 5;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 205;
  localparam int unsigned PRESSURE_PHASE = 3;
  localparam int unsigned PRESSURE_ITEMS = 30;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  tbo_cmd_if cmd_if ();
  tbo_res_if res_if ();

  int mismatch_count;
  int pending;
  int checked;

  // stimulus shaping flags shared by the driving processes
  bit          no_idle   = 1'b0;
  bit          pressure  = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned amount_scale = 16;
  int          sent_by_cmd[4];
  int          phases_run = 0;

  typed_buffer_occupancy_tracker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_if),
    .res_o       (res_if)
  );

  tbo_occupancy_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .cmd_mon_i        (cmd_if),
    .res_mon_i        (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one command item and wait until the tracker takes it
  task automatic send_command(command_e c, logic [1:0] dt, logic [2:0] m,
                              logic [AMT_W-1:0] amt);
    int unsigned gap;
    gap = (no_idle || pressure) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= c;
    cmd_if.data_type <= dt;
    cmd_if.type_mask <= m;
    cmd_if.amount    <= amt;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
    sent_by_cmd[c]++;
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // write the whole register set once the tracker has gone quiet
  task automatic configure(logic mode, logic [CAP_W-1:0] shared_cap,
                           logic [CAP_W-1:0] in_cap, logic [CAP_W-1:0] wt_cap,
                           logic [CAP_W-1:0] out_cap);
    int unsigned top_cap;
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    put_reg(REG_BUFFER_MODE, CFG_DAT_W'(mode));
    put_reg(REG_SHARED_CAPACITY, shared_cap);
    put_reg(REG_INPUT_CAPACITY, in_cap);
    put_reg(REG_WEIGHT_CAPACITY, wt_cap);
    put_reg(REG_OUTPUT_CAPACITY, out_cap);
    cfg_we <= 1'b0;
    // random amounts scale with the largest capacity so adds often fit
    top_cap = shared_cap;
    if (in_cap > top_cap) top_cap = in_cap;
    if (wt_cap > top_cap) top_cap = wt_cap;
    if (out_cap > top_cap) top_cap = out_cap;
    amount_scale = top_cap / 3 + 4;
    phases_run++;
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5: return CAP_W'($urandom_range(1, 400));
      default: return CAP_W'($urandom);
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1:       return AMT_W'($urandom);
      default: return AMT_W'($urandom_range(0, amount_scale));
    endcase
  endfunction

  task automatic send_random_command();
    int unsigned sel;
    command_e    c;
    logic [1:0]  dt;
    sel = $urandom_range(0, 9);
    if (sel < 4) c = CMD_ADD;
    else if (sel < 6) c = CMD_EVICT;
    else if (sel < 8) c = CMD_REMOVE;
    else c = CMD_READY;
    if ($urandom_range(0, 11) == 0) dt = TYPE_UNKNOWN;
    else dt = 2'($urandom_range(TYPE_INPUT, TYPE_OUTPUT));
    send_command(c, dt, 3'($urandom), pick_amount());
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles in which nothing moves
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // main stimulus
  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_ADD;
    cmd_if.data_type = TYPE_INPUT;
    cmd_if.type_mask = '0;
    cmd_if.amount    = '0;
    res_if.ready     = 1'b0;
    for (int i = 0; i < 4; i++) sent_by_cmd[i] = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset registers: shared mode, every capacity zero
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, '0);
    send_command(CMD_ADD,    TYPE_WEIGHT,  3'b000, 16'd1);
    send_command(CMD_EVICT,  TYPE_OUTPUT,  3'b000, '1);
    send_command(CMD_REMOVE, TYPE_INPUT,   3'b000, '0);
    send_command(CMD_READY,  TYPE_INPUT,   3'b000, '1);
    send_command(CMD_ADD,    TYPE_UNKNOWN, 3'b111, '0);

    // shared mode at the largest capacity
    configure(MODE_SHARED, '1, '1, '1, '1);
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, '1);
    send_command(CMD_ADD,    TYPE_WEIGHT,  3'b000, 16'd1);
    send_command(CMD_READY,  TYPE_WEIGHT,  3'b111, 16'd1);
    send_command(CMD_READY,  TYPE_OUTPUT,  3'b001, '1);
    send_command(CMD_REMOVE, TYPE_WEIGHT,  3'b000, 16'd1);
    send_command(CMD_EVICT,  TYPE_INPUT,   3'b000, 16'd100);
    send_command(CMD_EVICT,  TYPE_UNKNOWN, 3'b000, 16'd5);
    send_command(CMD_REMOVE, TYPE_UNKNOWN, 3'b000, '0);

    // switch mode with levels held, then push every counter to its top
    configure(MODE_INDEPENDENT, '1, '1, '1, '1);
    send_command(CMD_ADD,    TYPE_WEIGHT,  3'b000, '1);
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, 16'd101);
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, 16'd100);
    send_command(CMD_ADD,    TYPE_OUTPUT,  3'b000, '1);
    send_command(CMD_READY,  TYPE_INPUT,   3'b111, '1);
    send_command(CMD_READY,  TYPE_INPUT,   3'b110, '0);

    // zero input capacity reads as full
    configure(MODE_INDEPENDENT, '1, '0, '1, '1);
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, '0);
    send_command(CMD_EVICT,  TYPE_INPUT,   3'b000, '1);
    send_command(CMD_ADD,    TYPE_INPUT,   3'b000, 16'd1);
    send_command(CMD_REMOVE, TYPE_OUTPUT,  3'b000, '1);

    // random phases, mode alternating with levels carried over
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(p[0] ? MODE_INDEPENDENT : MODE_SHARED, pick_capacity(),
                pick_capacity(), pick_capacity(), pick_capacity());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == PRESSURE_PHASE && k == PHASE_ITEMS / 2) begin
          hold_req = 1'b1;
          pressure = 1'b1;
        end
        if (p == PRESSURE_PHASE && k == PHASE_ITEMS / 2 + PRESSURE_ITEMS) begin
          pressure = 1'b0;
        end
        send_random_command();
      end
    end
    no_idle = 1'b0;

    // drain
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d add, %0d evict, %0d remove and %0d readiness items over %0d settings",
             sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_EVICT], sent_by_cmd[CMD_REMOVE],
             sent_by_cmd[CMD_READY], phases_run + 1);
    $display("%0d result items compared, %0d field mismatches", checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tbo_pkg.sv
rtl/core/tbo_stream_if.sv
rtl/core/tbo_cfg_regs.sv
rtl/core/tbo_level_core.sv
rtl/core/typed_buffer_occupancy_tracker_unit.sv
verif/tbo_occupancy_checker.sv
verif/tb_top.sv
